// ----- rtl/core/rcf_pkg.sv -----
`default_nettype none

package rcf_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam int COLOR_W = 32;
   localparam int DIM_W   = 7;
   localparam int POS_W   = 12;
   localparam int PROD_W  = 2 * POS_W;
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 2;

   localparam logic [COLOR_W-1:0] BG_RESET = 32'hFFCC_CCCC;
   localparam logic [COLOR_W-1:0] FG_RESET = 32'hFF33_3333;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RECT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

   localparam logic [IDX_W-1:0] REG_FG_COLOR = 2'd0;
   localparam logic [IDX_W-1:0] REG_BG_COLOR = 2'd1;
   localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd2;
   localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd3;

   // shared square unit operations
   localparam logic SQ_OP_MUL = 1'b0;
   localparam logic SQ_OP_DSQ = 1'b1;

   typedef struct packed {
      logic             op;
      logic [POS_W-1:0] opa;
      logic [POS_W-1:0] opb;
   } sq_req_type;

endpackage

`default_nettype wire

// ----- rtl/core/rcf_sq_unit.sv -----
`default_nettype none

module rcf_sq_unit (
   input  wire logic                       clock,
   input  wire rcf_pkg::sq_req_type        sq_req,
   output logic [rcf_pkg::PROD_W-1:0]      sq_prod
);
   import rcf_pkg::*;

   logic [POS_W-1:0]  diff;
   logic [POS_W-1:0]  mul_a;
   logic [POS_W-1:0]  mul_b;
   logic [PROD_W-1:0] prod_ff;

   // absolute difference feeds both multiplier inputs when squaring a distance
   assign diff  = (sq_req.opa >= sq_req.opb) ? (sq_req.opa - sq_req.opb)
                                             : (sq_req.opb - sq_req.opa);
   assign mul_a = (sq_req.op == SQ_OP_DSQ) ? diff : sq_req.opa;
   assign mul_b = (sq_req.op == SQ_OP_DSQ) ? diff : sq_req.opb;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign sq_prod = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rect_circle_fill_engine.sv -----
`default_nettype none

// channel  | direction | handshake               | payload
// req      | in        | req_valid / req_stall   | cmd, x_pos, y_pos, size_a, size_b
// rsp      | out       | rsp_valid / rsp_stall   | pixel_value, done_cmd
// csr      | in        | csr_write_enable        | csr_index, csr_write_data
//
// clear and rect step through one pixel per cycle from a running address
// circle uses the shared square unit, which gives dx^2 for each pixel
// an on-canvas read runs an address multiply and a registered store read; an
// off-canvas read or any fill on an empty canvas goes straight to the response
// after reset a sweep fills the store with the reset background colour BG_RESET,
// req_stall stays high meanwhile; csr writes are taken at any time
// a finished result waits in the output register while the next command is taken

module rect_circle_fill_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [rcf_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [rcf_pkg::POS_W-1:0]    req_x_pos,
   input  wire logic [rcf_pkg::POS_W-1:0]    req_y_pos,
   input  wire logic [rcf_pkg::POS_W-1:0]    req_size_a,
   input  wire logic [rcf_pkg::POS_W-1:0]    req_size_b,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [rcf_pkg::COLOR_W-1:0]       rsp_pixel_value,
   output logic [rcf_pkg::CMD_W-1:0]         rsp_done_cmd,
   input  wire logic                         csr_write_enable,
   input  wire logic [rcf_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [rcf_pkg::COLOR_W-1:0]  csr_write_data
);
   import rcf_pkg::*;

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RSQ   = 4'd2;
   localparam logic [3:0] ST_ROW   = 4'd3;
   localparam logic [3:0] ST_PIX   = 4'd4;
   localparam logic [3:0] ST_WR    = 4'd5;
   localparam logic [3:0] ST_RADDR = 4'd6;
   localparam logic [3:0] ST_RMEM  = 4'd7;
   localparam logic [3:0] ST_RDATA = 4'd8;
   localparam logic [3:0] ST_RESP  = 4'd9;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   logic [3:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [POS_W-1:0]    x_ff, x_in;
   logic [POS_W-1:0]    y_ff, y_in;
   logic [POS_W-1:0]    a_ff, a_in;
   logic [POS_W-1:0]    b_ff, b_in;
   logic [DIM_W-1:0]    w_ff, w_in;
   logic [DIM_W-1:0]    h_ff, h_in;
   logic [COL_W-1:0]    px_ff, px_in;
   logic [ROW_W-1:0]    py_ff, py_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PROD_W-1:0]   r2_ff, r2_in;
   logic [PROD_W-1:0]   dy2_ff, dy2_in;
   logic [COLOR_W-1:0]  res_ff, res_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_pixel_ff;
   logic [CMD_W-1:0]    rsp_cmd_ff;
   logic                rsp_load;

   logic [COLOR_W-1:0]  fg_ff;
   logic [COLOR_W-1:0]  bg_ff;
   logic [DIM_W-1:0]    cw_ff;
   logic [DIM_W-1:0]    ch_ff;
   logic [DIM_W-1:0]    w_act;
   logic [DIM_W-1:0]    h_act;

   logic [COLOR_W-1:0]  mem [STORE_DEPTH];
   logic [COLOR_W-1:0]  rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [COLOR_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;

   sq_req_type          sq_req;
   logic [PROD_W-1:0]   sq_prod;

   logic                pix_hit;
   logic [POS_W:0]      rect_x_end;
   logic [POS_W:0]      rect_y_end;
   logic [PROD_W:0]     dist2;
   logic                last_col;
   logic                last_row;

   rcf_sq_unit u_sq (
      .clock   (clock),
      .sq_req  (sq_req),
      .sq_prod (sq_prod)
   );

   assign w_act = (cw_ff > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cw_ff;
   assign h_act = (ch_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : ch_ff;

   assign rect_x_end = {1'b0, x_ff} + {1'b0, a_ff};
   assign rect_y_end = {1'b0, y_ff} + {1'b0, b_ff};
   assign dist2      = {1'b0, sq_prod} + {1'b0, dy2_ff};
   assign last_col   = (DIM_W'(px_ff) == w_ff - DIM_W'(1));
   assign last_row   = (DIM_W'(py_ff) == h_ff - DIM_W'(1));

   always_comb begin
      pix_hit = 1'b0;
      case (cmd_ff)
         CMD_CLEAR: pix_hit = 1'b1;
         CMD_RECT: pix_hit = (POS_W'(px_ff) >= x_ff) &&
                             ((POS_W + 1)'(px_ff) < rect_x_end) &&
                             (POS_W'(py_ff) >= y_ff) &&
                             ((POS_W + 1)'(py_ff) < rect_y_end);
         CMD_CIRCLE: pix_hit = (dist2 <= {1'b0, r2_ff});
         default: pix_hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      addr_in    = addr_ff;
      r2_in      = r2_ff;
      dy2_in     = dy2_ff;
      res_in     = res_ff;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = (cmd_ff == CMD_CLEAR) ? bg_ff : fg_ff;
      mem_raddr  = sq_prod[ADDR_W-1:0] + ADDR_W'(x_ff);
      sq_req.op  = SQ_OP_MUL;
      sq_req.opa = '0;
      sq_req.opb = '0;

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = BG_RESET;
            addr_in   = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               x_in    = req_x_pos;
               y_in    = req_y_pos;
               a_in    = req_size_a;
               b_in    = req_size_b;
               w_in    = w_act;
               h_in    = h_act;
               px_in   = '0;
               py_in   = '0;
               addr_in = '0;
               res_in  = '0;
               if (req_cmd == CMD_READ) begin
                  if ((req_x_pos < POS_W'(w_act)) && (req_y_pos < POS_W'(h_act))) begin
                     state_in = ST_RADDR;
                  end else begin
                     state_in = ST_RESP;
                  end
               end else if ((w_act == '0) || (h_act == '0)) begin
                  state_in = ST_RESP;
               end else if (req_cmd == CMD_CIRCLE) begin
                  state_in = ST_RSQ;
               end else begin
                  state_in = ST_WR;
               end
            end
         end
         ST_RSQ: begin
            sq_req.op  = SQ_OP_MUL;
            sq_req.opa = a_ff;
            sq_req.opb = a_ff;
            state_in   = ST_ROW;
         end
         ST_ROW: begin
            sq_req.op  = SQ_OP_DSQ;
            sq_req.opa = POS_W'(py_ff);
            sq_req.opb = y_ff;
            // radius squared is still on the unit output only on the first row
            if (py_ff == '0) begin
               r2_in = sq_prod;
            end
            state_in = ST_PIX;
         end
         ST_PIX: begin
            sq_req.op  = SQ_OP_DSQ;
            sq_req.opa = POS_W'(px_ff);
            sq_req.opb = x_ff;
            // dy^2 is on the unit output only right after the row step
            if (px_ff == '0) begin
               dy2_in = sq_prod;
            end
            state_in   = ST_WR;
         end
         ST_WR: begin
            mem_we = pix_hit;
            if (last_col) begin
               px_in = '0;
               if (last_row) begin
                  state_in = ST_RESP;
               end else begin
                  py_in    = py_ff + ROW_W'(1);
                  addr_in  = addr_ff + ADDR_W'(1);
                  state_in = (cmd_ff == CMD_CIRCLE) ? ST_ROW : ST_WR;
               end
            end else begin
               px_in    = px_ff + COL_W'(1);
               addr_in  = addr_ff + ADDR_W'(1);
               state_in = (cmd_ff == CMD_CIRCLE) ? ST_PIX : ST_WR;
            end
         end
         ST_RADDR: begin
            sq_req.op  = SQ_OP_MUL;
            sq_req.opa = y_ff;
            sq_req.opb = POS_W'(w_ff);
            state_in   = ST_RMEM;
         end
         ST_RMEM: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            res_in   = rdata_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         cw_ff        <= DIM_W'(MAX_WIDTH);
         ch_ff        <= DIM_W'(MAX_HEIGHT);
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_FG_COLOR: fg_ff <= csr_write_data;
               REG_BG_COLOR: bg_ff <= csr_write_data;
               REG_WIDTH:    cw_ff <= csr_write_data[DIM_W-1:0];
               REG_HEIGHT:   ch_ff <= csr_write_data[DIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      w_ff   <= w_in;
      h_ff   <= h_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      r2_ff  <= r2_in;
      dy2_ff <= dy2_in;
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_pixel_ff <= res_ff;
         rsp_cmd_ff   <= cmd_ff;
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_done_cmd    = rsp_cmd_ff;

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result loaded outside the response step");

   a_scan_in_canvas: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (DIM_W'(px_ff) < w_ff) && (DIM_W'(py_ff) < h_ff))
      else $error("fill scan left the canvas");

   a_addr_tracks_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |->
         addr_ff == ADDR_W'(ADDR_W'(py_ff) * ADDR_W'(w_ff) + ADDR_W'(px_ff)))
      else $error("running address out of step with row and column");

   a_read_addr_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMEM) |-> sq_prod < PROD_W'(STORE_DEPTH))
      else $error("read row offset beyond the frame store");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_INIT) || (state_ff == ST_WR))
      else $error("store written outside a fill");

endmodule

`default_nettype wire
